>>> src/whm_pkg.sv
`timescale 1ns / 1ps
package whm_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Store select codes
  typedef enum logic [1:0] {
    SEL_DURATION = 2'd0,
    SEL_SIZE     = 2'd1,
    SEL_AREA     = 2'd2,
    SEL_EXTENT   = 2'd3
  } sel_e;

  // Register indexes
  typedef enum logic [1:0] {
    REG_LATTICE = 2'd0,
    REG_WSIZE   = 2'd1,
    REG_WBASE   = 2'd2,
    REG_XLIMIT  = 2'd3
  } reg_idx_e;

  localparam int unsigned ADDR_W = 4;

  localparam logic [9:0]  LATTICE_RST = 10'd1000;
  localparam logic [16:0] WSIZE_RST   = 17'd65536;
  localparam logic [31:0] WBASE_RST   = 32'd0;
  localparam logic [11:0] XLIMIT_RST  = 12'd2000;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] duration;
    logic [31:0] size_value;
    logic [31:0] area_value;
    logic [15:0] extent;
    logic [1:0]  hist_select;
    logic [15:0] bin_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] max_value;
    logic [31:0] sample_count;
    logic        size_beyond;
    logic        area_beyond;
    logic        range_error;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  lattice_size;
    logic [16:0] window_size;
    logic [31:0] window_base;
    logic [11:0] x_limit;
  } cfg_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  hist_select;
    logic [15:0] bin_index;
    logic [16:0] duration;
    logic [31:0] size_value;
    logic [31:0] area_value;
    logic [15:0] extent;
    logic [31:0] size_off;
    logic [31:0] area_off;
    logic        upd_base;
    logic        bump_size;
    logic        bump_area;
    logic        set_sb;
    logic        set_ab;
    logic        set_range;
    logic        rd_total;
    logic        rd_in;
  } item_t;

endpackage

>>> src/windowed_multi_histogram_core.sv
`timescale 1ns / 1ps
// Windowed multi-histogram core.
// Input words (add sample, read bin, clear, no-op) enter through push/full;
// results leave through empty/pop, one result word for every input word.
// Settings are written over the APB-style port while the core is idle, a rule
// the user keeps that the core does not enforce: lattice_size, window_size,
// window_base and x_limit at byte offsets 0/4/8/12. A two-entry queue after the
// classifier lets words be pushed while the bin engine is busy or a result
// waits to be popped. In the engine, add and read go through address,
// read-modify-write on the bin RAMs and result load; a no-op goes straight
// to result load; a clear runs the one-entry-per-cycle zeroing sweep over
// max(DURATION_BINS, WINDOW_BINS, EXTENT_BINS) addresses, then result load.
// After reset the same sweep runs and no word leaves the queue until it ends;
// settings writes are taken meanwhile.
// When the receiver does not pop, the finished result stays on the output
// register, the engine holds its next result, and full rises once the
// queue has filled.
module windowed_multi_histogram_core import whm_pkg::*; #(
  parameter int unsigned DURATION_BINS = 1024,
  parameter int unsigned WINDOW_BINS   = 65536,
  parameter int unsigned EXTENT_BINS   = 2048,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  in_word_t          in_word_i,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_word_o
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, take, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lattice_size <= LATTICE_RST;
      cfg_q.window_size  <= WSIZE_RST;
      cfg_q.window_base  <= WBASE_RST;
      cfg_q.x_limit      <= XLIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_LATTICE: cfg_q.lattice_size <= pwdata[9:0];
        REG_WSIZE:   cfg_q.window_size  <= pwdata[16:0];
        REG_WBASE:   cfg_q.window_base  <= pwdata;
        REG_XLIMIT:  cfg_q.x_limit      <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_LATTICE: prdata = 32'(cfg_q.lattice_size);
      REG_WSIZE:   prdata = 32'(cfg_q.window_size);
      REG_WBASE:   prdata = cfg_q.window_base;
      REG_XLIMIT:  prdata = 32'(cfg_q.x_limit);
      default:     prdata = '0;
    endcase
  end

  whm_front #(
    .DURATION_BINS(DURATION_BINS),
    .WINDOW_BINS  (WINDOW_BINS),
    .EXTENT_BINS  (EXTENT_BINS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg_q),
    .push_i (push),
    .word_i (in_word_i),
    .full_o (full),
    .valid_o(item_valid),
    .item_o (item),
    .take_i (take)
  );

  whm_back #(
    .DURATION_BINS(DURATION_BINS),
    .WINDOW_BINS  (WINDOW_BINS),
    .EXTENT_BINS  (EXTENT_BINS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .valid_i(item_valid),
    .item_i (item),
    .take_o (take),
    .empty_o(empty),
    .word_o (out_word_o),
    .pop_i  (pop)
  );

endmodule

>>> src/whm_ram.sv
`timescale 1ns / 1ps
module whm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/whm_front.sv
`timescale 1ns / 1ps
module whm_front import whm_pkg::*; #(
  parameter int unsigned DURATION_BINS = 1024,
  parameter int unsigned WINDOW_BINS   = 65536,
  parameter int unsigned EXTENT_BINS   = 2048
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  in_word_t word_i,
  output logic     full_o,
  output logic     valid_o,
  output item_t    item_o,
  input  logic     take_i
);

  localparam int unsigned DEPTH = 2;

  item_t       cls;
  logic [31:0] eff_w;
  logic [31:0] ws32;
  logic        d_ok, x_bad, base0, live;
  logic        s_ge, a_ge, s_in, a_in;
  logic        idx_in;

  item_t      fifo_q [DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  // Classify the incoming word
  always_comb begin
    ws32   = 32'(cfg_i.window_size);
    eff_w  = (ws32 < 32'(WINDOW_BINS)) ? ws32 : 32'(WINDOW_BINS);
    base0  = (cfg_i.window_base == 32'd0);
    d_ok   = (word_i.duration != 17'd0) &&
             (word_i.duration <= 17'(cfg_i.lattice_size)) &&
             (32'(word_i.duration) < 32'(DURATION_BINS));
    x_bad  = (word_i.extent >= 16'(cfg_i.x_limit)) ||
             (32'(word_i.extent) >= 32'(EXTENT_BINS));
    live   = d_ok && !x_bad;

    cls.size_off = word_i.size_value - cfg_i.window_base;
    cls.area_off = word_i.area_value - cfg_i.window_base;
    s_ge   = word_i.size_value >= cfg_i.window_base;
    a_ge   = word_i.area_value >= cfg_i.window_base;
    s_in   = cls.size_off < eff_w;
    a_in   = cls.area_off < eff_w;

    unique case (sel_e'(word_i.hist_select))
      SEL_DURATION: idx_in = 32'(word_i.bin_index) < 32'(DURATION_BINS);
      SEL_SIZE,
      SEL_AREA:     idx_in = 32'(word_i.bin_index) < eff_w;
      SEL_EXTENT:   idx_in = 32'(word_i.bin_index) < 32'(EXTENT_BINS);
      default:      idx_in = 1'b0;
    endcase

    cls.command     = word_i.command;
    cls.hist_select = word_i.hist_select;
    cls.bin_index   = word_i.bin_index;
    cls.duration    = word_i.duration;
    cls.size_value  = word_i.size_value;
    cls.area_value  = word_i.area_value;
    cls.extent      = word_i.extent;
    cls.upd_base    = live && base0;
    cls.bump_size   = live && s_ge && s_in;
    cls.bump_area   = live && a_ge && a_in;
    cls.set_sb      = live && s_ge && !s_in;
    cls.set_ab      = live && a_ge && !a_in;
    cls.set_range   = d_ok && x_bad;
    cls.rd_total    = (word_i.bin_index == 16'd0) && base0;
    cls.rd_in       = idx_in;
  end

  // Two-entry queue toward the back end
  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = fifo_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> src/whm_back.sv
`timescale 1ns / 1ps
module whm_back import whm_pkg::*; #(
  parameter int unsigned DURATION_BINS = 1024,
  parameter int unsigned WINDOW_BINS   = 65536,
  parameter int unsigned EXTENT_BINS   = 2048,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  item_t     item_i,
  output logic      take_o,
  output logic      empty_o,
  output out_word_t word_o,
  input  logic      pop_i
);

  localparam int unsigned DUR_AW = $clog2(DURATION_BINS);
  localparam int unsigned WIN_AW = $clog2(WINDOW_BINS);
  localparam int unsigned EXT_AW = $clog2(EXTENT_BINS);
  localparam int unsigned MAXD_A = (WINDOW_BINS > DURATION_BINS) ? WINDOW_BINS : DURATION_BINS;
  localparam int unsigned MAXD   = (MAXD_A > EXTENT_BINS) ? MAXD_A : EXTENT_BINS;
  localparam int unsigned SW     = $clog2(MAXD);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_WR, ST_CLR, ST_OUT
  } state_e;

  state_e           state_q;
  item_t            item_q;
  logic [SW-1:0]    sweep_q;
  logic             clr_emit_q;
  logic [31:0]      bin_q;
  logic [16:0]      dmax_q;
  logic [31:0]      smax_q, amax_q;
  logic [15:0]      xmax_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic             sb_q, ab_q, re_q;
  logic             res_valid_q;
  out_word_t        res_q;

  logic                   sweeping, sweep_end, can_out, load_out;
  logic                   dur_we, win_s_we, win_a_we, ext_we;
  logic [DUR_AW-1:0]      dur_ra, dur_wa;
  logic [WIN_AW-1:0]      siz_ra, siz_wa, are_ra, are_wa;
  logic [EXT_AW-1:0]      ext_ra, ext_wa;
  logic [COUNT_WIDTH-1:0] dur_rd, siz_rd, are_rd, ext_rd;
  logic [COUNT_WIDTH-1:0] dur_wd, siz_wd, are_wd, ext_wd;
  logic [COUNT_WIDTH-1:0] sel_rd;
  logic [31:0]            max_sel;
  logic                   is_read;

  // Address and write control for the four stores
  always_comb begin
    is_read   = (item_q.command == CMD_READ);
    sweeping  = (state_q == ST_CLR);
    sweep_end = (sweep_q == SW'(MAXD - 1));
    dur_ra = is_read ? DUR_AW'(item_q.bin_index) : DUR_AW'(item_q.duration);
    ext_ra = is_read ? EXT_AW'(item_q.bin_index) : EXT_AW'(item_q.extent);
    siz_ra = is_read ? WIN_AW'(item_q.bin_index) : WIN_AW'(item_q.size_off);
    are_ra = is_read ? WIN_AW'(item_q.bin_index) : WIN_AW'(item_q.area_off);

    dur_wa = sweeping ? DUR_AW'(sweep_q) : dur_ra;
    ext_wa = sweeping ? EXT_AW'(sweep_q) : ext_ra;
    siz_wa = sweeping ? WIN_AW'(sweep_q) : siz_ra;
    are_wa = sweeping ? WIN_AW'(sweep_q) : are_ra;

    dur_wd = (sweeping || dur_rd == CNT_MAX) ? (sweeping ? '0 : dur_rd) : dur_rd + 1'b1;
    ext_wd = (sweeping || ext_rd == CNT_MAX) ? (sweeping ? '0 : ext_rd) : ext_rd + 1'b1;
    siz_wd = (sweeping || siz_rd == CNT_MAX) ? (sweeping ? '0 : siz_rd) : siz_rd + 1'b1;
    are_wd = (sweeping || are_rd == CNT_MAX) ? (sweeping ? '0 : are_rd) : are_rd + 1'b1;

    dur_we   = sweeping ? ({1'b0, sweep_q} < (SW+1)'(DURATION_BINS))
                        : (state_q == ST_WR && !is_read && item_q.upd_base);
    ext_we   = sweeping ? ({1'b0, sweep_q} < (SW+1)'(EXTENT_BINS))
                        : (state_q == ST_WR && !is_read && item_q.upd_base);
    win_s_we = sweeping ? ({1'b0, sweep_q} < (SW+1)'(WINDOW_BINS))
                        : (state_q == ST_WR && !is_read && item_q.bump_size);
    win_a_we = sweeping ? ({1'b0, sweep_q} < (SW+1)'(WINDOW_BINS))
                        : (state_q == ST_WR && !is_read && item_q.bump_area);

    unique case (sel_e'(item_q.hist_select))
      SEL_DURATION: sel_rd = dur_rd;
      SEL_SIZE:     sel_rd = siz_rd;
      SEL_AREA:     sel_rd = are_rd;
      SEL_EXTENT:   sel_rd = ext_rd;
      default:      sel_rd = '0;
    endcase

    unique case (sel_e'(item_q.hist_select))
      SEL_DURATION: max_sel = 32'(dmax_q);
      SEL_SIZE:     max_sel = smax_q;
      SEL_AREA:     max_sel = amax_q;
      SEL_EXTENT:   max_sel = 32'(xmax_q);
      default:      max_sel = '0;
    endcase

    can_out  = !res_valid_q || pop_i;
    load_out = (state_q == ST_OUT) && can_out;
    take_o   = (state_q == ST_IDLE) && valid_i;
  end

  whm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DURATION_BINS)) u_dur_ram (
    .clk_i, .we_i(dur_we), .waddr_i(dur_wa), .wdata_i(dur_wd),
    .raddr_i(dur_ra), .rdata_o(dur_rd)
  );
  whm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(WINDOW_BINS)) u_size_ram (
    .clk_i, .we_i(win_s_we), .waddr_i(siz_wa), .wdata_i(siz_wd),
    .raddr_i(siz_ra), .rdata_o(siz_rd)
  );
  whm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(WINDOW_BINS)) u_area_ram (
    .clk_i, .we_i(win_a_we), .waddr_i(are_wa), .wdata_i(are_wd),
    .raddr_i(are_ra), .rdata_o(are_rd)
  );
  whm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(EXTENT_BINS)) u_ext_ram (
    .clk_i, .we_i(ext_we), .waddr_i(ext_wa), .wdata_i(ext_wd),
    .raddr_i(ext_ra), .rdata_o(ext_rd)
  );

  assign empty_o = !res_valid_q;
  assign word_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      item_q <= item_i;
    end
  end

  // Sequencer: state, running values and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      sweep_q     <= '0;
      clr_emit_q  <= 1'b0;
      bin_q       <= '0;
      dmax_q      <= '0;
      smax_q      <= '0;
      amax_q      <= '0;
      xmax_q      <= '0;
      total_q     <= '0;
      sb_q        <= 1'b0;
      ab_q        <= 1'b0;
      re_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      // A new result replaces the popped one in the same cycle
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            bin_q <= '0;
            unique case (cmd_e'(item_i.command))
              CMD_ADD, CMD_READ: state_q <= ST_RD;
              CMD_CLEAR: begin
                sweep_q    <= '0;
                clr_emit_q <= 1'b1;
                state_q    <= ST_CLR;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_WR;
        end
        ST_WR: begin
          if (is_read) begin
            if (item_q.rd_total) begin
              bin_q <= 32'(total_q);
            end else if (item_q.rd_in) begin
              bin_q <= 32'(sel_rd);
            end
          end else begin
            if (item_q.upd_base) begin
              if (item_q.duration > dmax_q)   dmax_q <= item_q.duration;
              if (item_q.size_value > smax_q) smax_q <= item_q.size_value;
              if (item_q.area_value > amax_q) amax_q <= item_q.area_value;
              if (item_q.extent > xmax_q)     xmax_q <= item_q.extent;
              if (total_q != CNT_MAX)         total_q <= total_q + 1'b1;
            end
            if (item_q.set_sb)    sb_q <= 1'b1;
            if (item_q.set_ab)    ab_q <= 1'b1;
            if (item_q.set_range) re_q <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_end) begin
            dmax_q  <= '0;
            smax_q  <= '0;
            amax_q  <= '0;
            xmax_q  <= '0;
            total_q <= '0;
            sb_q    <= 1'b0;
            ab_q    <= 1'b0;
            re_q    <= 1'b0;
            state_q <= clr_emit_q ? ST_OUT : ST_IDLE;
          end
        end
        ST_OUT: begin
          if (can_out) begin
            res_q.bin_count    <= bin_q;
            res_q.max_value    <= max_sel;
            res_q.sample_count <= 32'(total_q);
            res_q.size_beyond  <= sb_q;
            res_q.area_beyond  <= ab_q;
            res_q.range_error  <= re_q;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
